// ===== rtl/assert_macros.svh =====
// assertion macros used by the waypoint follow controller rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/wfc_pkg.sv =====
// types, constants and tables for the waypoint follow controller
// no dependencies
package wfc_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int CORDIC_STEPS  = 16;

  localparam int WP_AW  = $clog2(MAX_WAYPOINTS);
  localparam int IDX_W  = WP_AW + 1;
  localparam int ITER_W = $clog2(CORDIC_STEPS);

  // cordic datapath and Q5.30 angle widths
  localparam int CW = 38;
  localparam int ZW = 35;

  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
  localparam logic signed [15:0] ARM_REST  = -16'sd8192;
  localparam logic signed [15:0] HAND_REST = 16'sd8192;
  localparam logic [7:0] ACT_RETRACT = 8'd2;
  localparam logic [31:0] SLEW_CAP_US = 32'd16000000;
  // elapsed*4096/1e6 = elapsed*64/15625; ceil(2^44 / 15625), result in bits 53:38
  localparam logic [30:0] STEP_RECIP = 31'd1125899907;

  localparam logic [1:0] CFG_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_SPEED   = 2'd1;
  localparam logic [1:0] CFG_POS_TOL = 2'd2;
  localparam logic [1:0] CFG_YAW_TOL = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] PASS_HEAD  = 2'd0;
  localparam logic [1:0] PASS_PLANE = 2'd1;
  localparam logic [1:0] PASS_SPACE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATE,
    ST_RD_CUR,
    ST_RD_PREV,
    ST_CALC,
    ST_CORD_START,
    ST_CORD_WAIT,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_DIV_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               updated;
    logic signed [15:0] drive_x;
    logic signed [15:0] drive_y;
    logic signed [15:0] turn_rate;
    logic               joints_write;
    logic signed [15:0] arm_command;
    logic signed [15:0] hand_command;
    logic               task_active;
  } result_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314856;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043836;
      5'd3:  v = 31'd133525158;
      5'd4:  v = 31'd67021686;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775850;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194282;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      5'd24: v = 31'd63;
      5'd25: v = 31'd31;
      5'd26: v = 31'd15;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/wfc_cordic.sv =====
// iterative vectoring cordic: one micro-rotation per cycle
// depends on wfc_pkg
module wfc_cordic (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [wfc_pkg::CW-1:0] x_in,
  input  logic signed [wfc_pkg::CW-1:0] y_in,
  output logic                       busy,
  output logic                       done,
  output logic signed [wfc_pkg::ZW-1:0] ang,
  output logic signed [wfc_pkg::CW-1:0] mag
);
  import wfc_pkg::*;

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [ITER_W-1:0]    iter;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [ZW-1:0] at;

  always_comb begin
    sx = y >>> iter;
    sy = x >>> iter;
    at = ZW'(signed'({1'b0, atan_q30(5'(iter))}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        iter <= '0;
        if (x_in == '0 && y_in == '0) begin
          x    <= '0;
          y    <= '0;
          z    <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (x_in < 0) begin
            // rotate into the right half plane first
            x <= -x_in;
            y <= -y_in;
            z <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
          end else begin
            x <= x_in;
            y <= y_in;
            z <= '0;
          end
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + sx;
          y <= y - sy;
          z <= z + at;
        end else begin
          x <= x - sx;
          y <= y + sy;
          z <= z - at;
        end
        iter <= iter + ITER_W'(1);
        if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ang = z;
  assign mag = x;

endmodule

// ===== rtl/waypoint_follow_controller.sv =====
// waypoint follow controller: waypoint table, control sequencer, output register
// a load result is valid the cycle after its transfer, a gated, idle or finishing tick
// once the gate state has decided it; a full tick runs gate, current and previous reads,
// calc, three cordic passes, low and high scaling per length pass, slew multiply and finish
// one item in work at a time; input stalls until idle and the last result has moved
// synchronous active-high reset clears control state; the table is undefined until loaded
module waypoint_follow_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [5:0]  waypoint_slot,
  input  logic        last_waypoint,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [7:0]  action_code,
  input  logic signed [14:0] heading,
  input  logic [31:0] sim_time_us,
  input  logic signed [15:0] arm_angle,
  input  logic signed [15:0] hand_angle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        updated,
  output logic signed [15:0] drive_x,
  output logic signed [15:0] drive_y,
  output logic signed [15:0] turn_rate,
  output logic        joints_write,
  output logic signed [15:0] arm_command,
  output logic signed [15:0] hand_command,
  output logic        task_active
);
  import wfc_pkg::*;
  `include "assert_macros.svh"

  state_t state, state_next;

  logic [19:0] period;
  logic [14:0] speed_lim;
  logic [30:0] pos_tol;
  logic [14:0] yaw_tol;

  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic             active;
  logic [31:0]      last_tick;

  logic signed [31:0] px, py, pz;
  logic signed [14:0] hdg;
  logic signed [15:0] arm_in, hand_in;
  logic [31:0]        now;

  logic [103:0]       wp_mem [MAX_WAYPOINTS];
  logic [103:0]       rd_data;
  logic [WP_AW-1:0]   rd_addr;
  logic signed [31:0] tx, ty, tz;
  logic [7:0]         tact;

  logic signed [32:0] ex, ey, ez, hx, hy;
  logic [1:0]         pass;
  logic signed [17:0] hd;
  logic [CW-1:0]      len1;
  logic [CW-1:0]      dpos;
  logic [61:0]        acc;
  logic [31:0]        elapsed;
  logic [54:0]        step_prod;
  logic [15:0]        quo;

  result_t res, out_r;
  logic    res_load;
  logic    accept;
  logic    load_ok;

  logic                 c_start, c_busy, c_done;
  logic signed [CW-1:0] c_x, c_y, c_mag;
  logic signed [ZW-1:0] c_ang;
  logic [CW-1:0]        mag_pos;
  logic [41:0]          prod_lo;
  logic [43:0]          prod_hi;
  logic [61:0]          acc_sum;
  logic signed [35:0]   ang_rnd;

  logic        late;
  logic [31:0] elapsed_c;
  logic        gated;
  logic        idx_bad;

  logic signed [17:0] dyaw0, dyaw;
  logic [17:0]        ayaw;
  logic               turning;
  logic signed [19:0] w3;
  logic signed [19:0] lim20;
  logic signed [15:0] turn_c;
  logic signed [15:0] arm_tgt, hand_tgt;
  logic [15:0]        step;
  logic               reached;

  function automatic logic signed [15:0] drive_of(input logic signed [32:0] e,
                                                  input logic [14:0] lim);
    logic signed [34:0] v;
    logic signed [34:0] l16;
    logic signed [34:0] shr;
    v   = 35'(e) + (35'(e) <<< 1);
    l16 = signed'({16'b0, lim, 4'b0});
    shr = v >>> 4;
    if (v > l16) return signed'({1'b0, lim});
    else if (v < -l16) return -signed'({1'b0, lim});
    else return shr[15:0];
  endfunction

  function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                              input logic signed [15:0] tgt,
                                              input logic [15:0] stp);
    logic signed [17:0] err;
    logic signed [17:0] s;
    err = 18'(tgt) - 18'(cur);
    s   = signed'({2'b0, stp});
    if (err > s) err = s;
    else if (err < -s) err = -s;
    return 16'(18'(cur) + err);
  endfunction

  wfc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .x_in  (c_x),
    .y_in  (c_y),
    .busy  (c_busy),
    .done  (c_done),
    .ang   (c_ang),
    .mag   (c_mag)
  );

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign load_ok  = int'(waypoint_slot) < MAX_WAYPOINTS;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= 20'd10000;
      speed_lim <= 15'd1229;
      pos_tol   <= 31'd5243;
      yaw_tol   <= 15'd205;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PERIOD:  period    <= cfg_data[19:0];
        CFG_SPEED:   speed_lim <= cfg_data[14:0];
        CFG_POS_TOL: pos_tol   <= cfg_data;
        CFG_YAW_TOL: yaw_tol   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // waypoint table, x in the low word, action on top
  always_ff @(posedge clk) begin
    if (accept && operation == OP_LOAD && load_ok)
      wp_mem[WP_AW'(waypoint_slot)] <= {action_code, point_z, point_y, point_x};
    rd_data <= wp_mem[rd_addr];
  end

  always_comb begin
    rd_addr = (state == ST_RD_CUR) ? WP_AW'(idx) : WP_AW'(idx - IDX_W'(1));

    late      = now < last_tick;
    elapsed_c = late ? 32'd0 : now - last_tick;
    gated     = elapsed_c < {12'b0, period};
    idx_bad   = (idx >= count) || (int'(idx) >= MAX_WAYPOINTS);

    mag_pos = c_mag[CW-1] ? '0 : c_mag;
    prod_lo = mag_pos[17:0] * INV_GAIN_Q24;
    prod_hi = mag_pos[CW-1:18] * INV_GAIN_Q24;
    acc_sum = acc + {prod_hi, 18'b0};
    ang_rnd = 36'(c_ang) + 36'sd131072;

    step_prod = elapsed[23:0] * STEP_RECIP;

    dyaw0 = hd - 18'(hdg);
    if (dyaw0 > PI_Q12) dyaw = dyaw0 - TWO_PI_Q12;
    else if (dyaw0 < -PI_Q12) dyaw = dyaw0 + TWO_PI_Q12;
    else dyaw = dyaw0;
    ayaw    = dyaw[17] ? 18'(-dyaw) : 18'(dyaw);
    turning = ayaw >= {3'b0, yaw_tol};
    w3      = 20'(dyaw) + (20'(dyaw) <<< 1);
    lim20   = signed'({5'b0, speed_lim});
    if (w3 > lim20) turn_c = 16'(lim20);
    else if (w3 < -lim20) turn_c = 16'(-lim20);
    else turn_c = w3[15:0];
    if (turning || tact == ACT_RETRACT) begin
      arm_tgt  = ARM_REST;
      hand_tgt = HAND_REST;
    end else begin
      arm_tgt  = '0;
      hand_tgt = '0;
    end
    reached = !turning && (dpos < CW'(pos_tol));
    step    = (elapsed >= SLEW_CAP_US) ? 16'hFFFF : quo;

    c_start = state == ST_CORD_START;
    case (pass)
      PASS_HEAD: begin
        c_x = (idx == '0) ? CW'(ex) : CW'(hx);
        c_y = (idx == '0) ? CW'(ey) : CW'(hy);
      end
      PASS_PLANE: begin
        c_x = CW'(ex);
        c_y = CW'(ey);
      end
      default: begin
        c_x = signed'(len1);
        c_y = CW'(ez);
      end
    endcase
  end

  // sequencer: next state and result
  always_comb begin
    state_next = state;
    res        = '0;
    res_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_LOAD) begin
            res_load        = 1'b1;
            res.task_active = active || (load_ok && last_waypoint);
          end else begin
            state_next = ST_GATE;
          end
        end
      end
      ST_GATE: begin
        if (gated) begin
          res_load        = 1'b1;
          res.task_active = active;
          state_next      = ST_IDLE;
        end else if (!active) begin
          res_load         = 1'b1;
          res.updated      = 1'b1;
          res.joints_write = 1'b1;
          res.arm_command  = ARM_REST;
          res.hand_command = HAND_REST;
          state_next       = ST_IDLE;
        end else if (idx_bad) begin
          // ran past the list: finishing tick drives nothing
          res_load    = 1'b1;
          res.updated = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          state_next = ST_RD_CUR;
        end
      end
      ST_RD_CUR:     state_next = ST_RD_PREV;
      ST_RD_PREV:    state_next = ST_CALC;
      ST_CALC:       state_next = ST_CORD_START;
      ST_CORD_START: state_next = ST_CORD_WAIT;
      ST_CORD_WAIT: begin
        if (c_done) state_next = (pass == PASS_HEAD) ? ST_CORD_START : ST_SCALE_LO;
      end
      ST_SCALE_LO: state_next = ST_SCALE_HI;
      ST_SCALE_HI: state_next = (pass == PASS_PLANE) ? ST_CORD_START : ST_DIV_RUN;
      ST_DIV_RUN:  state_next = ST_FINISH;
      ST_FINISH: begin
        res_load         = 1'b1;
        res.updated      = 1'b1;
        res.joints_write = 1'b1;
        res.task_active  = active;
        if (turning) begin
          res.turn_rate = turn_c;
        end else begin
          res.drive_x = drive_of(ex, speed_lim);
          res.drive_y = drive_of(ey, speed_lim);
        end
        res.arm_command  = slew(arm_in, arm_tgt, step);
        res.hand_command = slew(hand_in, hand_tgt, step);
        state_next       = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // task control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      active    <= 1'b0;
      last_tick <= '0;
    end else begin
      if (accept && operation == OP_LOAD && load_ok && last_waypoint) begin
        count  <= IDX_W'(waypoint_slot) + IDX_W'(1);
        idx    <= '0;
        active <= 1'b1;
      end
      if (state == ST_GATE) begin
        if (gated) begin
          if (late) last_tick <= now;
        end else begin
          last_tick <= now;
          if (active && idx_bad) begin
            active <= 1'b0;
            idx    <= '0;
          end
        end
      end
      if (state == ST_FINISH && reached) idx <= idx + IDX_W'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && operation == OP_TICK) begin
      px      <= point_x;
      py      <= point_y;
      pz      <= point_z;
      hdg     <= heading;
      arm_in  <= arm_angle;
      hand_in <= hand_angle;
      now     <= sim_time_us;
    end
    case (state)
      ST_GATE: begin
        elapsed <= elapsed_c;
        pass    <= PASS_HEAD;
      end
      ST_RD_PREV: begin
        tx   <= rd_data[31:0];
        ty   <= rd_data[63:32];
        tz   <= rd_data[95:64];
        tact <= rd_data[103:96];
      end
      ST_CALC: begin
        ex <= 33'(tx) - 33'(px);
        ey <= 33'(ty) - 33'(py);
        ez <= 33'(tz) - 33'(pz);
        hx <= 33'(tx) - 33'(signed'(rd_data[31:0]));
        hy <= 33'(ty) - 33'(signed'(rd_data[63:32]));
      end
      ST_CORD_WAIT: begin
        if (c_done && pass == PASS_HEAD) begin
          hd   <= ang_rnd[35:18];
          pass <= PASS_PLANE;
        end
      end
      ST_SCALE_LO: acc <= 62'(prod_lo) + 62'(24'h800000);
      ST_SCALE_HI: begin
        if (pass == PASS_PLANE) begin
          len1 <= acc_sum[61:24];
          pass <= PASS_SPACE;
        end else begin
          dpos <= acc_sum[61:24];
        end
      end
      // slew step floor(elapsed*4096/1e6) by reciprocal multiply, exact below the cap
      ST_DIV_RUN: quo <= step_prod[53:38];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_load) out_r <= res;
  end

  assign updated      = out_r.updated;
  assign drive_x      = out_r.drive_x;
  assign drive_y      = out_r.drive_y;
  assign turn_rate    = out_r.turn_rate;
  assign joints_write = out_r.joints_write;
  assign arm_command  = out_r.arm_command;
  assign hand_command = out_r.hand_command;
  assign task_active  = out_r.task_active;

  `ASSERT_IMPLY(a_accept_in_idle, clk, rst, in_valid && !in_stall, state == ST_IDLE)
  `ASSERT_IMPLY(a_index_in_list, clk, rst, active, idx <= count)
  `ASSERT_NEVER(a_result_overrun, clk, rst, res_load && out_valid && out_stall)
  `ASSERT_IMPLY(a_cordic_owned, clk, rst, c_busy, state == ST_CORD_WAIT)

endmodule

// ===== tb/tb_waypoint_follow_controller.sv =====
// self-checking testbench for waypoint_follow_controller
// uses wfc_pkg for the result layout, register indexes, operations and rest angles
`timescale 1ns / 100ps

module tb_waypoint_follow_controller;
  import wfc_pkg::*;

  localparam int STEPS = 16;
  localparam longint ATAN_TBL [0:15] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767};
  localparam longint HALF_TURN = 12868;
  localparam longint FULL_TURN = 25736;

  typedef struct {
    logic               op;
    logic [5:0]         slot;
    logic               last;
    int                 x;
    int                 y;
    int                 z;
    logic [7:0]         act;
    logic signed [14:0] hdg;
    int unsigned        t;
    shortint            arm;
    shortint            hand;
  } item_t;

  // mirror of the controller state plus the queue of results still owed
  class follow_scoreboard;
    int          wx [64];
    int          wy [64];
    int          wz [64];
    logic [7:0]  wact [64];
    int          count;
    int          cur;
    bit          active;
    int          arm_tgt;
    int          hand_tgt;
    int unsigned last_us;
    int unsigned period_us;
    int unsigned speed_lim;
    int unsigned pos_tol;
    int unsigned yaw_tol;
    result_t     owed [$];
    int          errors;
    int          checked;
    int          moves;
    int          finishes;

    function new();
      count = 0; cur = 0; active = 0;
      arm_tgt = ARM_REST; hand_tgt = HAND_REST; last_us = 0;
      period_us = 10000; speed_lim = 1229; pos_tol = 5243; yaw_tol = 205;
      errors = 0; checked = 0; moves = 0; finishes = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [30:0] val);
      case (idx)
        CFG_PERIOD:  period_us = 32'(val[19:0]);
        CFG_SPEED:   speed_lim = 32'(val[14:0]);
        CFG_POS_TOL: pos_tol   = 32'(val[30:0]);
        default:     yaw_tol   = 32'(val[14:0]);
      endcase
    endfunction

    function void vector_cordic(longint xi, longint yi, output longint ang,
                                output longint mag);
      longint x, y, z, sx, sy;
      x = xi; y = yi; z = 0;
      if (x == 0 && y == 0) begin
        ang = 0; mag = 0;
        return;
      end
      if (x < 0) begin
        z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
        x = -x; y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        sx = y >>> i;
        sy = x >>> i;
        if (y >= 0) begin
          x += sx; y -= sy; z += ATAN_TBL[i];
        end else begin
          x -= sx; y += sy; z -= ATAN_TBL[i];
        end
      end
      ang = z; mag = x;
    endfunction

    function longint span(longint a, longint b);
      longint ang, mag;
      vector_cordic(a, b, ang, mag);
      if (mag < 0) mag = 0;
      return (mag * longint'(INV_GAIN_Q24) + (longint'(1) << 23)) >>> 24;
    endfunction

    function longint bearing(longint dx, longint dy);
      longint ang, mag;
      vector_cordic(dx, dy, ang, mag);
      return (ang + (longint'(1) << 17)) >>> 18;
    endfunction

    // heading the controller wants from pose (px, py); valid only while active
    function longint aim(longint px, longint py);
      if (cur == 0) return bearing(wx[0] - px, wy[0] - py);
      return bearing(wx[cur] - wx[cur-1], wy[cur] - wy[cur-1]);
    endfunction

    function longint drive(longint e);
      longint v, lim;
      v = e * 3;
      lim = speed_lim;
      if (v > lim * 16) return lim;
      if (v < -lim * 16) return -lim;
      return v >>> 4;
    endfunction

    function longint slew(longint c, longint target, longint stp);
      longint e;
      e = target - c;
      if (e > stp) e = stp;
      else if (e < -stp) e = -stp;
      return c + e;
    endfunction

    function void note_item(item_t it);
      result_t     r;
      longint      tx, ty, tz, dyaw, dpos, ex, ey, stp, w, lim;
      int unsigned el;
      r = '0;
      if (it.op == OP_LOAD) begin
        wx[it.slot] = it.x; wy[it.slot] = it.y; wz[it.slot] = it.z;
        wact[it.slot] = it.act;
        if (it.last) begin
          count = it.slot + 1; cur = 0; active = 1;
        end
        r.task_active = active;
        owed.push_back(r);
        return;
      end
      if (it.t < last_us) last_us = it.t;
      el = it.t - last_us;
      if (el < period_us) begin
        r.task_active = active;
        owed.push_back(r);
        return;
      end
      last_us = it.t;
      r.updated = 1;
      if (!active) begin
        r.joints_write = 1;
        r.arm_command = ARM_REST;
        r.hand_command = HAND_REST;
        owed.push_back(r);
        return;
      end
      if (cur >= count) begin
        active = 0; cur = 0; finishes++;
        owed.push_back(r);
        return;
      end
      tx = wx[cur]; ty = wy[cur]; tz = wz[cur];
      dyaw = aim(it.x, it.y) - longint'(it.hdg);
      if (dyaw > HALF_TURN) dyaw -= FULL_TURN;
      else if (dyaw < -HALF_TURN) dyaw += FULL_TURN;
      ex = tx - it.x;
      ey = ty - it.y;
      dpos = span(span(ex, ey), tz - it.z);
      if ((dyaw < 0 ? -dyaw : dyaw) >= longint'(yaw_tol)) begin
        w = dyaw * 3;
        lim = speed_lim;
        r.turn_rate = 16'((w > lim) ? lim : (w < -lim) ? -lim : w);
        arm_tgt = ARM_REST; hand_tgt = HAND_REST;
      end else begin
        r.drive_x = 16'(drive(ex));
        r.drive_y = 16'(drive(ey));
        if (wact[cur] == ACT_RETRACT) begin
          arm_tgt = ARM_REST; hand_tgt = HAND_REST;
        end else begin
          arm_tgt = 0; hand_tgt = 0;
        end
        if (dpos < longint'(pos_tol)) begin
          cur++; moves++;
        end
      end
      stp = (longint'(el) * 4096) / 1000000;
      if (stp > 65535) stp = 65535;
      r.joints_write = 1;
      r.arm_command = 16'(slew(it.arm, arm_tgt, stp));
      r.hand_command = 16'(slew(it.hand, hand_tgt, stp));
      r.task_active = active;
      owed.push_back(r);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (owed.size() == 0) begin
        $error("result transfer with no result owed");
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      cmp("updated", e.updated, a.updated);
      cmp("drive_x", e.drive_x, a.drive_x);
      cmp("drive_y", e.drive_y, a.drive_y);
      cmp("turn_rate", e.turn_rate, a.turn_rate);
      cmp("joints_write", e.joints_write, a.joints_write);
      cmp("arm_command", e.arm_command, a.arm_command);
      cmp("hand_command", e.hand_command, a.hand_command);
      cmp("task_active", e.task_active, a.task_active);
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;
  logic        in_valid, in_stall, out_valid, out_stall;
  item_t       cur_item;
  logic        updated, joints_write, task_active;
  logic signed [15:0] drive_x, drive_y, turn_rate, arm_command, hand_command;

  follow_scoreboard sb;
  int          send_pct, recv_pct, phase_no;
  bit          held;
  int          hold_left;
  logic [63:0] loaded;
  int unsigned now_us;
  int          sent;

  waypoint_follow_controller dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(cur_item.op), .waypoint_slot(cur_item.slot),
    .last_waypoint(cur_item.last),
    .point_x(cur_item.x), .point_y(cur_item.y), .point_z(cur_item.z),
    .action_code(cur_item.act), .heading(cur_item.hdg),
    .sim_time_us(cur_item.t),
    .arm_angle(cur_item.arm), .hand_angle(cur_item.hand),
    .out_valid(out_valid), .out_stall(out_stall),
    .updated(updated), .drive_x(drive_x), .drive_y(drive_y),
    .turn_rate(turn_rate), .joints_write(joints_write),
    .arm_command(arm_command), .hand_command(hand_command),
    .task_active(task_active)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

  // receiver side; one long hold-off at the start of the last phase
  initial begin
    out_stall = 1;
    held = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (phase_no == 3 && !held) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall = 1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_item(cur_item);
    if (!rst && out_valid && !out_stall)
      sb.check_result('{updated, drive_x, drive_y, turn_rate, joints_write,
                        arm_command, hand_command, task_active});
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(item_t it);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    cur_item = it;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_load(int slot, bit last, int x, int y, int z, int act);
    item_t it;
    it = cur_item;
    it.op = OP_LOAD; it.slot = 6'(slot); it.last = last;
    it.x = x; it.y = y; it.z = z; it.act = 8'(act);
    loaded[slot] = 1;
    send(it);
  endtask

  task automatic send_tick(int x, int y, int z, int hdg, int unsigned t,
                           int arm, int hand);
    item_t it;
    it = cur_item;
    it.op = OP_TICK; it.x = x; it.y = y; it.z = z; it.hdg = 15'(hdg);
    it.t = t; it.arm = 16'(arm); it.hand = 16'(hand);
    it.slot = 6'($urandom); it.last = 1'($urandom); it.act = 8'($urandom);
    send(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_write = 1; cfg_index = idx; cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_write = 0;
  endtask

  task automatic setup(int unsigned per, int unsigned spd, int unsigned ptol,
                       int unsigned ytol);
    int n;
    n = 0;
    in_valid = 0;
    while (sb.owed.size() != 0 && n < 50000) begin
      @(negedge clk);
      n++;
    end
    repeat (100) @(negedge clk);
    write_reg(CFG_PERIOD, 31'(per));
    write_reg(CFG_SPEED, 31'(spd));
    write_reg(CFG_POS_TOL, 31'(ptol));
    write_reg(CFG_YAW_TOL, 31'(ytol));
  endtask

  function automatic int unsigned next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) now_us = now_us - $urandom_range(1, 50000);
    else if (r < 14) now_us = now_us + $urandom_range(0, sb.period_us);
    else if (r < 16) now_us = $urandom;
    else now_us = now_us + sb.period_us + $urandom_range(0, 400000);
    return now_us;
  endfunction

  function automatic bit slots_ready(int s);
    for (int i = 0; i <= s; i++)
      if (!loaded[i]) return 0;
    return 1;
  endfunction

  // a short loaded path followed by ticks that track it
  task automatic run_path();
    int k, bx, by, px, py, hdg, ang;
    k = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 64) : $urandom_range(1, 5);
    bx = $urandom_range(0, 2097152) - 1048576;
    by = $urandom_range(0, 2097152) - 1048576;
    for (int i = 0; i < k; i++) begin
      bx += $urandom_range(0, 262144) - 131072;
      by += $urandom_range(0, 262144) - 131072;
      send_load(i, i == k - 1, bx, by, $urandom_range(0, 4000) - 2000,
                ($urandom_range(0, 2) == 0) ? ACT_RETRACT : $urandom_range(0, 255));
    end
    for (int n = 0; n < 3 * k + 6 && sb.active; n++) begin
      if (sb.cur < sb.count) begin
        px = sb.wx[sb.cur] + $urandom_range(0, 8000) - 4000;
        py = sb.wy[sb.cur] + $urandom_range(0, 8000) - 4000;
        ang = int'(sb.aim(px, py));
      end else begin
        px = $urandom; py = $urandom; ang = 0;
      end
      hdg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25736) - 12868
                                         : ang + $urandom_range(0, 200) - 100;
      send_tick(px, py, $urandom_range(0, 4000) - 2000, hdg, next_time(),
                $urandom_range(0, 16384) - 8192, $urandom_range(0, 16384) - 8192);
    end
  endtask

  task automatic run_phase(int items, int sp, int rp);
    int s;
    send_pct = sp;
    recv_pct = rp;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) < 7) begin
        run_path();
      end else if ($urandom_range(0, 1) == 0) begin
        s = $urandom_range(0, 63);
        loaded[s] = 1;
        send_load(s, slots_ready(s) && $urandom_range(0, 3) == 0,
                  $urandom, $urandom, $urandom, $urandom_range(0, 255));
      end else begin
        send_tick($urandom, $urandom, $urandom, $urandom_range(0, 32767),
                  next_time(), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    cfg_write = 0; cfg_index = CFG_PERIOD; cfg_data = '0;
    in_valid = 0;
    cur_item = '{OP_LOAD, 6'd0, 1'b0, 0, 0, 0, 8'd0, 15'sd0, 0, 16'sd0, 16'sd0};
    loaded = '0;
    now_us = 0;
    phase_no = 0;
    send_pct = 0;
    recv_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: idle, gating, time going back, a three point path, finishing
    setup(10000, 1229, 5243, 205);
    send_tick(32'h7fffffff, 32'h80000000, 0, 0, 10000, 32767, -32768);
    send_tick(0, 0, 0, 0, 10500, 0, 0);
    send_tick(0, 0, 0, 0, 5000, 0, 0);
    send_load(63, 0, 32'h7fffffff, 32'h80000000, 32'h80000000, 255);
    send_load(0, 0, 0, 0, 0, ACT_RETRACT);
    send_load(1, 0, 65536, 0, 0, 7);
    send_load(2, 1, 65536, 65536, 0, 0);
    send_tick(0, 0, 0, 0, 100000, 1000, -1000);           // zero vector, reached
    send_tick(0, 0, 0, -16384, 200000, 0, 0);              // wraps once, turns
    send_tick(0, 0, 0, 0, 300000, -8192, 8192);            // aligned, saturated drive
    send_tick(65536, 0, 0, 0, 400000, 0, 0);
    send_tick(65536, 65536, 0, 6434, 500000, 0, 0);
    send_tick(0, 0, 0, 0, 600000, 0, 0);                   // past the end
    send_tick(0, 0, 0, 0, 700000, 0, 0);
    send_load(0, 1, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 2);
    send_tick(32'h7fffffff, 32'h80000000, 32'h80000000, 12868, 32'hffffffff,
              -32768, 32767);
    send_load(0, 1, 0, 0, 0, 1);
    send_tick(0, 0, 0, 0, 32'hffffffff, 0, 0);
    now_us = 0;
    send_tick(0, 0, 0, 0, 0, 0, 0);

    phase_no = 1;
    setup(0, 32767, 31'h7fffffff, 0);
    run_phase(200, 36, 79);
    phase_no = 2;
    setup(1000000, 0, 0, 32767);
    run_phase(200, 79, 36);
    setup(2500, 1229, 20000, 400);
    phase_no = 3;
    run_phase(200, 0, 0);

    in_valid = 0;
    setup(10000, 1229, 5243, 205);
    sb.errors += sb.owed.size();
    $display("checked %0d results; %0d waypoints reached, %0d paths finished,",
             sb.checked, sb.moves, sb.finishes);
    $display("over the reset setting, both extremes and a tracking setting");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
